/* rtl/sssd_pkg.sv */
// Shared types, constants and the hex-to-segment decode for the scan display.
// No dependencies; used by sssd_bin2bcd and seven_segment_scan_display.

package sssd_pkg;

    localparam int BIN_W = 14;          // 9999 fits in 14 bits
    localparam int BCD_W = 16;          // four decimal digits
    localparam int CNT_W = 4;           // counts BIN_W shift steps

    localparam logic [2:0] KIND_REFRESH  = 3'd0;
    localparam logic [2:0] KIND_BCD      = 3'd1;
    localparam logic [2:0] KIND_UNSIGNED = 3'd2;
    localparam logic [2:0] KIND_SIGNED   = 3'd3;
    localparam logic [2:0] KIND_COUPLES  = 3'd4;
    localparam logic [2:0] KIND_DP_ON    = 3'd5;
    localparam logic [2:0] KIND_DP_OFF   = 3'd6;

    localparam logic [15:0] MAX_UNSIGNED = 16'd9999;
    localparam logic [15:0] MAX_NEG_MAG  = 16'd999;
    localparam logic [7:0]  MAX_COUPLE   = 8'd99;
    localparam logic [7:0]  SIGN_RESET   = 8'h01;

    typedef struct packed {
        logic             start;
        logic [BIN_W-1:0] value;
    } conv_req_t;

    typedef struct packed {
        logic             done;
        logic [BCD_W-1:0] digits;
    } conv_rsp_t;

    function automatic logic [7:0] seg_of(input logic [3:0] nib);
        logic [7:0] seg;
        case (nib)
            4'h0: seg = 8'h3F;
            4'h1: seg = 8'h06;
            4'h2: seg = 8'h5B;
            4'h3: seg = 8'h4F;
            4'h4: seg = 8'h66;
            4'h5: seg = 8'h6D;
            4'h6: seg = 8'h7D;
            4'h7: seg = 8'h07;
            4'h8: seg = 8'h7F;
            4'h9: seg = 8'h6F;
            4'hA: seg = 8'h77;
            4'hB: seg = 8'h7C;
            4'hC: seg = 8'h58;
            4'hD: seg = 8'h5E;
            4'hE: seg = 8'h79;
            default: seg = 8'h71;
        endcase
        return seg;
    endfunction

endpackage

/* rtl/sssd_bin2bcd.sv */
// Bit-serial binary to BCD converter (shift-and-add-3), one input bit per cycle.
// Depends on sssd_pkg for widths and the request/response structs.

module sssd_bin2bcd (
    input  logic                aclk,
    input  logic                aresetn,
    input  sssd_pkg::conv_req_t req,
    output sssd_pkg::conv_rsp_t rsp
);

    logic [sssd_pkg::BIN_W-1:0] bin_reg, bin_next;
    logic [sssd_pkg::BCD_W-1:0] bcd_reg, bcd_next;
    logic [sssd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [sssd_pkg::BCD_W-1:0] adj;

    // Each digit of at least five gets three added before the shift.
    always_comb begin
        for (int i = 0; i < sssd_pkg::BCD_W / 4; i++) begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                        : bcd_reg[4*i +: 4];
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            bin_next  = req.value;
            bcd_next  = '0;
            cnt_next  = sssd_pkg::CNT_W'(sssd_pkg::BIN_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next = {adj[sssd_pkg::BCD_W-2:0], bin_reg[sssd_pkg::BIN_W-1]};
            bin_next = {bin_reg[sssd_pkg::BIN_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.digits = bcd_reg;

endmodule

/* rtl/seven_segment_scan_display.sv */
// Top level of the four-digit multiplexed seven-segment display controller.
// Depends on sssd_pkg and sssd_bin2bcd.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_valid / s_ready    kind, high_byte, low_byte, number, point_index
//  m_        out        m_valid / m_ready    segments, digit_select, refresh_valid, range_error
//  APB       in         psel/penable/pready  sign_pattern at byte address 0
//
// Refresh ticks, BCD writes, decimal-point requests and rejected numbers go straight to the hold
// state, which loads the output register once it is free. A number write runs 14 steps of the
// serial BCD converter before the hold state loads the output register; couples run it once per
// in-range half. s_ready stays low from acceptance until the output register is loaded, so one
// request is in flight at a time. A new request is taken while a result waits at m_;
// the next result holds until m_ready drains the output register.
// Reset is synchronous on aresetn and clears the digit patterns, points and scan.

module seven_segment_scan_display (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [7:0]  s_high_byte,
    input  logic [7:0]  s_low_byte,
    input  logic [15:0] s_number,
    input  logic [2:0]  s_point_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_segments,
    output logic [3:0]  m_digit_select,
    output logic        m_refresh_valid,
    output logic        m_range_error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [7:0]  sign_reg;
    logic [7:0]  pat_reg [4];
    logic [7:0]  pat_next [4];
    logic [3:0]  point_reg, point_next;
    logic [1:0]  scan_reg, scan_next;
    logic        neg_reg, neg_next;
    logic        couple_reg, couple_next;
    logic        phase_reg, phase_next;
    logic        lo_ok_reg, lo_ok_next;
    logic [7:0]  lo_reg, lo_next;
    logic [7:0]  pend_seg_reg, pend_seg_next;
    logic [3:0]  pend_sel_reg, pend_sel_next;
    logic        pend_rv_reg, pend_rv_next;
    logic        pend_err_reg, pend_err_next;
    logic        m_valid_reg;
    logic [7:0]  m_seg_reg;
    logic [3:0]  m_sel_reg;
    logic        m_rv_reg;
    logic        m_err_reg;

    sssd_pkg::conv_req_t conv_req;
    sssd_pkg::conv_rsp_t conv_rsp;

    logic        accept;
    logic        out_load;
    logic        cfg_write;
    logic [15:0] mag;
    logic        hi_ok;
    logic        lo_ok;
    logic [1:0]  pbit;

    sssd_bin2bcd u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (conv_req),
        .rsp     (conv_rsp)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_HOLD) && (!m_valid_reg || m_ready);
    assign mag      = ~s_number + 16'd1;
    assign hi_ok    = (s_high_byte <= sssd_pkg::MAX_COUPLE);
    assign lo_ok    = (s_low_byte <= sssd_pkg::MAX_COUPLE);
    assign pbit     = 2'(s_point_index - 3'd1);

    always_comb begin
        state_next    = state_reg;
        pat_next      = pat_reg;
        point_next    = point_reg;
        scan_next     = scan_reg;
        neg_next      = neg_reg;
        couple_next   = couple_reg;
        phase_next    = phase_reg;
        lo_ok_next    = lo_ok_reg;
        lo_next       = lo_reg;
        pend_seg_next = pend_seg_reg;
        pend_sel_next = pend_sel_reg;
        pend_rv_next  = pend_rv_reg;
        pend_err_next = pend_err_reg;
        conv_req      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pend_seg_next = '0;
                    pend_sel_next = '0;
                    pend_rv_next  = 1'b0;
                    pend_err_next = 1'b0;
                    couple_next   = 1'b0;
                    neg_next      = 1'b0;
                    state_next    = ST_HOLD;
                    case (s_kind)
                        sssd_pkg::KIND_REFRESH: begin
                            pend_seg_next = {point_reg[scan_reg], pat_reg[~scan_reg][6:0]};
                            pend_sel_next = 4'b0001 << scan_reg;
                            pend_rv_next  = 1'b1;
                            scan_next     = scan_reg + 2'd1;
                        end
                        sssd_pkg::KIND_BCD: begin
                            pat_next[0] = sssd_pkg::seg_of(s_high_byte[7:4]);
                            pat_next[1] = sssd_pkg::seg_of(s_high_byte[3:0]);
                            pat_next[2] = sssd_pkg::seg_of(s_low_byte[7:4]);
                            pat_next[3] = sssd_pkg::seg_of(s_low_byte[3:0]);
                        end
                        sssd_pkg::KIND_UNSIGNED: begin
                            if (s_number > sssd_pkg::MAX_UNSIGNED) begin
                                pend_err_next = 1'b1;
                            end else begin
                                conv_req.start = 1'b1;
                                conv_req.value = s_number[sssd_pkg::BIN_W-1:0];
                                state_next     = ST_CONV;
                            end
                        end
                        sssd_pkg::KIND_SIGNED: begin
                            if (s_number[15]) begin
                                if (mag > sssd_pkg::MAX_NEG_MAG) begin
                                    pend_err_next = 1'b1;
                                end else begin
                                    conv_req.start = 1'b1;
                                    conv_req.value = mag[sssd_pkg::BIN_W-1:0];
                                    neg_next       = 1'b1;
                                    state_next     = ST_CONV;
                                end
                            end else if (s_number > sssd_pkg::MAX_UNSIGNED) begin
                                pend_err_next = 1'b1;
                            end else begin
                                conv_req.start = 1'b1;
                                conv_req.value = s_number[sssd_pkg::BIN_W-1:0];
                                state_next     = ST_CONV;
                            end
                        end
                        sssd_pkg::KIND_COUPLES: begin
                            couple_next = 1'b1;
                            lo_ok_next  = lo_ok;
                            lo_next     = s_low_byte;
                            // Skip straight to the right couple when the left one is rejected.
                            if (hi_ok) begin
                                conv_req.start = 1'b1;
                                conv_req.value = sssd_pkg::BIN_W'(s_high_byte);
                                phase_next     = 1'b0;
                                state_next     = ST_CONV;
                            end else if (lo_ok) begin
                                conv_req.start = 1'b1;
                                conv_req.value = sssd_pkg::BIN_W'(s_low_byte);
                                phase_next     = 1'b1;
                                state_next     = ST_CONV;
                            end
                        end
                        sssd_pkg::KIND_DP_ON: begin
                            if (s_point_index inside {[3'd1:3'd4]}) begin
                                point_next[pbit] = 1'b1;
                            end
                        end
                        sssd_pkg::KIND_DP_OFF: begin
                            if (s_point_index inside {[3'd1:3'd4]}) begin
                                point_next[pbit] = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CONV: begin
                if (conv_rsp.done) begin
                    if (couple_reg) begin
                        if (!phase_reg) begin
                            pat_next[0] = sssd_pkg::seg_of(conv_rsp.digits[7:4]);
                            pat_next[1] = sssd_pkg::seg_of(conv_rsp.digits[3:0]);
                            if (lo_ok_reg) begin
                                conv_req.start = 1'b1;
                                conv_req.value = sssd_pkg::BIN_W'(lo_reg);
                                phase_next     = 1'b1;
                            end else begin
                                state_next = ST_HOLD;
                            end
                        end else begin
                            pat_next[2] = sssd_pkg::seg_of(conv_rsp.digits[7:4]);
                            pat_next[3] = sssd_pkg::seg_of(conv_rsp.digits[3:0]);
                            state_next  = ST_HOLD;
                        end
                    end else begin
                        pat_next[0] = neg_reg ? sign_reg
                                              : sssd_pkg::seg_of(conv_rsp.digits[15:12]);
                        pat_next[1] = sssd_pkg::seg_of(conv_rsp.digits[11:8]);
                        pat_next[2] = sssd_pkg::seg_of(conv_rsp.digits[7:4]);
                        pat_next[3] = sssd_pkg::seg_of(conv_rsp.digits[3:0]);
                        state_next  = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pat_reg     <= '{default: '0};
            point_reg   <= '0;
            scan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pat_reg   <= pat_next;
            point_reg <= point_next;
            scan_reg  <= scan_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        neg_reg      <= neg_next;
        couple_reg   <= couple_next;
        phase_reg    <= phase_next;
        lo_ok_reg    <= lo_ok_next;
        lo_reg       <= lo_next;
        pend_seg_reg <= pend_seg_next;
        pend_sel_reg <= pend_sel_next;
        pend_rv_reg  <= pend_rv_next;
        pend_err_reg <= pend_err_next;
        if (out_load) begin
            m_seg_reg <= pend_seg_reg;
            m_sel_reg <= pend_sel_reg;
            m_rv_reg  <= pend_rv_reg;
            m_err_reg <= pend_err_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_segments      = m_seg_reg;
    assign m_digit_select  = m_sel_reg;
    assign m_refresh_valid = m_rv_reg;
    assign m_range_error   = m_err_reg;

    // Configuration port: one register, word 0.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sign_reg <= sssd_pkg::SIGN_RESET;
        end else if (cfg_write) begin
            sign_reg <= pwdata[7:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {24'd0, sign_reg};

endmodule
